@@ rtl/core/bmhq_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmhq_pkg
// Shared types and codes for the binary min-heap priority queue.
// ---------------------------------------------------------------------------
package bmhq_pkg;

  // Widths of the beat fields.
  localparam int VAL_W  = 16;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  // Opcodes.
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_EX_LOAD,
    S_DOWN,
    S_RESP
  } bmhq_state_t;

endpackage

@@ rtl/core/bmhq_mem.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmhq_mem
// Heap storage: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module bmhq_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_a_addr,
  input  logic [$clog2(DEPTH)-1:0]   rd_b_addr,
  output logic [WIDTH-1:0]           rd_a_data,
  output logic [WIDTH-1:0]           rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read before write: a read issued on the edge after a write sees it.
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

@@ rtl/core/binary_min_heap_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binary_min_heap_queue
// Array-based binary min-heap priority queue held in a two-read-port memory.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): in_opcode selects insert of
//   in_value_in or extract of the minimum. One beat is taken at a time; the
//   block raises in_stall while it works on an item.
//   Result channel (out_valid / out_stall): exactly one beat per input beat,
//   carrying the extracted value (0 unless a successful extract), a status
//   (ok, full on insert, empty on extract) and the occupancy afterward.
//   The sift walks one heap level per cycle, up to log2(DEPTH) levels on
//   insert and one less on extract. An insert reads the parent and then
//   climbs; an extract first loads the root and the last entry, then
//   descends; a rejected insert or an empty extract goes straight to the
//   result state. The next beat is taken once the sequencer is back in
//   idle, after the result register loads.
//   The result sits in an output register, so a new item is accepted while
//   the previous result still waits; if the receiver stalls, the finished
//   item holds in the sequencer until the output register frees up.
//   Reset clears the occupancy and the handshake state; the memory is not
//   cleared, only entries below the occupancy are ever used.
// ---------------------------------------------------------------------------
module binary_min_heap_queue
  import bmhq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [VAL_W-1:0]  in_value_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VAL_W-1:0]  out_value_out,
  output logic [STAT_W-1:0] out_status,
  output logic [OCC_W-1:0]  out_occupancy
);

  // Stored width: values are kept at VALUE_BITS, but never more than the port.
  localparam int SW = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  bmhq_state_t       state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [SW-1:0]     val_r, val_nxt;
  logic [VAL_W-1:0]  res_val_r, res_val_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_val_r, out_val_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [OCC_W-1:0]  out_occ_r, out_occ_nxt;

  // Memory port signals.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;
  logic [AW-1:0] rd_a_addr, rd_b_addr;
  logic [SW-1:0] rd_a_data, rd_b_data;

  // Address arithmetic helpers.
  logic          in_accept;
  logic          out_free;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] up_parent;
  logic [AW-1:0] up_gparent;
  logic [IW-1:0] dn_left, dn_right, cnt_ext;
  logic          dn_pick_right;
  logic [SW-1:0] dn_cval;
  logic [AW-1:0] dn_pick;
  logic [AW:0]   dn_cl;
  logic [AW:0]   dn_cr;

  bmhq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (SW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Last used slot, and parent and grandparent of the sifting slot.
  assign count_m1   = count_r - 1'b1;
  assign up_parent  = AW'((pos_r - 1'b1) >> 1);
  assign up_gparent = AW'((up_parent - 1'b1) >> 1);

  // Children of the sifting slot and the smaller of the two.
  assign dn_left       = {1'b0, pos_r, 1'b1};
  assign dn_right      = dn_left + 1'b1;
  assign cnt_ext       = IW'(count_r);
  assign dn_pick_right = (dn_right < cnt_ext) && (rd_a_data > rd_b_data);
  assign dn_cval       = dn_pick_right ? rd_b_data : rd_a_data;
  assign dn_pick       = dn_pick_right ? dn_right[AW-1:0] : dn_left[AW-1:0];
  assign dn_cl         = {dn_pick, 1'b1};
  assign dn_cr         = dn_cl + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    res_val_nxt   = res_val_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    out_stat_nxt  = out_stat_r;
    out_occ_nxt   = out_occ_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = val_r;
    rd_a_addr     = '0;
    rd_b_addr     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_val_nxt  = '0;
          res_stat_nxt = ST_OK;
          if (in_opcode == OP_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              res_stat_nxt = ST_FULL;
              state_nxt    = S_RESP;
            end else begin
              // Place at the rear and fetch its parent.
              val_nxt   = in_value_in[SW-1:0];
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + 1'b1;
              rd_a_addr = AW'(count_m1 >> 1);
              state_nxt = S_UP;
            end
          end else begin
            if (count_r == '0) begin
              res_stat_nxt = ST_EMPTY;
              state_nxt    = S_RESP;
            end else begin
              // Fetch the root and the last entry together.
              rd_a_addr = '0;
              rd_b_addr = count_m1[AW-1:0];
              count_nxt = count_m1;
              state_nxt = S_EX_LOAD;
            end
          end
        end
      end

      S_UP: begin
        wr_en = 1'b1;
        if (pos_r != '0 && val_r < rd_a_data) begin
          // Move the parent down and climb one level.
          wr_data   = rd_a_data;
          pos_nxt   = up_parent;
          rd_a_addr = up_gparent;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_EX_LOAD: begin
        res_val_nxt = VAL_W'(rd_a_data);
        val_nxt     = rd_b_data;
        pos_nxt     = '0;
        rd_a_addr   = AW'(1);
        rd_b_addr   = AW'(2);
        state_nxt   = S_DOWN;
      end

      S_DOWN: begin
        wr_en = 1'b1;
        if (dn_left < cnt_ext && val_r > dn_cval) begin
          // Move the smaller child up and descend.
          wr_data   = dn_cval;
          pos_nxt   = dn_pick;
          rd_a_addr = dn_cl[AW-1:0];
          rd_b_addr = dn_cr[AW-1:0];
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_stat_nxt  = res_stat_r;
          out_occ_nxt   = OCC_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_val_r;
  assign out_status    = out_stat_r;
  assign out_occupancy = out_occ_r;

  // Occupancy never passes the heap size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("heap occupancy above DEPTH");

  // A full rejection reports a full heap.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_occupancy == OCC_W'(DEPTH))
    else $error("full status with heap not full");

  // An empty extract reports nothing held and a zero value.
  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_occupancy == '0 && out_value_out == '0))
    else $error("empty status with data");

  // A finished item reaches the output register once it is free.
  a_resp_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_free) |=> (out_valid && state_r == S_IDLE))
    else $error("finished item not issued");

endmodule
